@@ rtl/hpk_pkg.sv @@
// hpk_pkg: shared types, constants and the static huffman code table
// used by every module of the hpack huffman encoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package hpk_pkg;

    localparam int unsigned CODE_W  = 30;
    localparam int unsigned LEN_W   = 5;
    localparam int unsigned PEND_W  = 7;
    localparam int unsigned ACC_W   = CODE_W + PEND_W;
    localparam int unsigned WORD_W  = 40;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned NBITS_W = 6;

    // one queued group of bits, left aligned, with its byte count
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [CNT_W-1:0]  count;
        logic              fin;
    } t_entry;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
    } t_code;

    function automatic t_code code_lookup(input logic [7:0] sym);
        t_code c;
        c = '0;
        case (sym)
            8'd0: c = {5'd13, 30'h1ff8};        8'd1: c = {5'd23, 30'h7fffd8};
            8'd2: c = {5'd28, 30'hfffffe2};     8'd3: c = {5'd28, 30'hfffffe3};
            8'd4: c = {5'd28, 30'hfffffe4};     8'd5: c = {5'd28, 30'hfffffe5};
            8'd6: c = {5'd28, 30'hfffffe6};     8'd7: c = {5'd28, 30'hfffffe7};
            8'd8: c = {5'd28, 30'hfffffe8};     8'd9: c = {5'd24, 30'hffffea};
            8'd10: c = {5'd30, 30'h3ffffffc};   8'd11: c = {5'd28, 30'hfffffe9};
            8'd12: c = {5'd28, 30'hfffffea};    8'd13: c = {5'd30, 30'h3ffffffd};
            8'd14: c = {5'd28, 30'hfffffeb};    8'd15: c = {5'd28, 30'hfffffec};
            8'd16: c = {5'd28, 30'hfffffed};    8'd17: c = {5'd28, 30'hfffffee};
            8'd18: c = {5'd28, 30'hfffffef};    8'd19: c = {5'd28, 30'hffffff0};
            8'd20: c = {5'd28, 30'hffffff1};    8'd21: c = {5'd28, 30'hffffff2};
            8'd22: c = {5'd30, 30'h3ffffffe};   8'd23: c = {5'd28, 30'hffffff3};
            8'd24: c = {5'd28, 30'hffffff4};    8'd25: c = {5'd28, 30'hffffff5};
            8'd26: c = {5'd28, 30'hffffff6};    8'd27: c = {5'd28, 30'hffffff7};
            8'd28: c = {5'd28, 30'hffffff8};    8'd29: c = {5'd28, 30'hffffff9};
            8'd30: c = {5'd28, 30'hffffffa};    8'd31: c = {5'd28, 30'hffffffb};
            8'd32: c = {5'd6, 30'h14};          8'd33: c = {5'd10, 30'h3f8};
            8'd34: c = {5'd10, 30'h3f9};        8'd35: c = {5'd12, 30'hffa};
            8'd36: c = {5'd13, 30'h1ff9};       8'd37: c = {5'd6, 30'h15};
            8'd38: c = {5'd8, 30'hf8};          8'd39: c = {5'd11, 30'h7fa};
            8'd40: c = {5'd10, 30'h3fa};        8'd41: c = {5'd10, 30'h3fb};
            8'd42: c = {5'd8, 30'hf9};          8'd43: c = {5'd11, 30'h7fb};
            8'd44: c = {5'd8, 30'hfa};          8'd45: c = {5'd6, 30'h16};
            8'd46: c = {5'd6, 30'h17};          8'd47: c = {5'd6, 30'h18};
            8'd48: c = {5'd5, 30'h0};           8'd49: c = {5'd5, 30'h1};
            8'd50: c = {5'd5, 30'h2};           8'd51: c = {5'd6, 30'h19};
            8'd52: c = {5'd6, 30'h1a};          8'd53: c = {5'd6, 30'h1b};
            8'd54: c = {5'd6, 30'h1c};          8'd55: c = {5'd6, 30'h1d};
            8'd56: c = {5'd6, 30'h1e};          8'd57: c = {5'd6, 30'h1f};
            8'd58: c = {5'd7, 30'h5c};          8'd59: c = {5'd8, 30'hfb};
            8'd60: c = {5'd15, 30'h7ffc};       8'd61: c = {5'd6, 30'h20};
            8'd62: c = {5'd12, 30'hffb};        8'd63: c = {5'd10, 30'h3fc};
            8'd64: c = {5'd13, 30'h1ffa};       8'd65: c = {5'd6, 30'h21};
            8'd66: c = {5'd7, 30'h5d};          8'd67: c = {5'd7, 30'h5e};
            8'd68: c = {5'd7, 30'h5f};          8'd69: c = {5'd7, 30'h60};
            8'd70: c = {5'd7, 30'h61};          8'd71: c = {5'd7, 30'h62};
            8'd72: c = {5'd7, 30'h63};          8'd73: c = {5'd7, 30'h64};
            8'd74: c = {5'd7, 30'h65};          8'd75: c = {5'd7, 30'h66};
            8'd76: c = {5'd7, 30'h67};          8'd77: c = {5'd7, 30'h68};
            8'd78: c = {5'd7, 30'h69};          8'd79: c = {5'd7, 30'h6a};
            8'd80: c = {5'd7, 30'h6b};          8'd81: c = {5'd7, 30'h6c};
            8'd82: c = {5'd7, 30'h6d};          8'd83: c = {5'd7, 30'h6e};
            8'd84: c = {5'd7, 30'h6f};          8'd85: c = {5'd7, 30'h70};
            8'd86: c = {5'd7, 30'h71};          8'd87: c = {5'd7, 30'h72};
            8'd88: c = {5'd8, 30'hfc};          8'd89: c = {5'd7, 30'h73};
            8'd90: c = {5'd8, 30'hfd};          8'd91: c = {5'd13, 30'h1ffb};
            8'd92: c = {5'd19, 30'h7fff0};      8'd93: c = {5'd13, 30'h1ffc};
            8'd94: c = {5'd14, 30'h3ffc};       8'd95: c = {5'd6, 30'h22};
            8'd96: c = {5'd15, 30'h7ffd};       8'd97: c = {5'd5, 30'h3};
            8'd98: c = {5'd6, 30'h23};          8'd99: c = {5'd5, 30'h4};
            8'd100: c = {5'd6, 30'h24};         8'd101: c = {5'd5, 30'h5};
            8'd102: c = {5'd6, 30'h25};         8'd103: c = {5'd6, 30'h26};
            8'd104: c = {5'd6, 30'h27};         8'd105: c = {5'd5, 30'h6};
            8'd106: c = {5'd7, 30'h74};         8'd107: c = {5'd7, 30'h75};
            8'd108: c = {5'd6, 30'h28};         8'd109: c = {5'd6, 30'h29};
            8'd110: c = {5'd6, 30'h2a};         8'd111: c = {5'd5, 30'h7};
            8'd112: c = {5'd6, 30'h2b};         8'd113: c = {5'd7, 30'h76};
            8'd114: c = {5'd6, 30'h2c};         8'd115: c = {5'd5, 30'h8};
            8'd116: c = {5'd5, 30'h9};          8'd117: c = {5'd6, 30'h2d};
            8'd118: c = {5'd7, 30'h77};         8'd119: c = {5'd7, 30'h78};
            8'd120: c = {5'd7, 30'h79};         8'd121: c = {5'd7, 30'h7a};
            8'd122: c = {5'd7, 30'h7b};         8'd123: c = {5'd15, 30'h7ffe};
            8'd124: c = {5'd11, 30'h7fc};       8'd125: c = {5'd14, 30'h3ffd};
            8'd126: c = {5'd13, 30'h1ffd};      8'd127: c = {5'd28, 30'hffffffc};
            8'd128: c = {5'd20, 30'hfffe6};     8'd129: c = {5'd22, 30'h3fffd2};
            8'd130: c = {5'd20, 30'hfffe7};     8'd131: c = {5'd20, 30'hfffe8};
            8'd132: c = {5'd22, 30'h3fffd3};    8'd133: c = {5'd22, 30'h3fffd4};
            8'd134: c = {5'd22, 30'h3fffd5};    8'd135: c = {5'd23, 30'h7fffd9};
            8'd136: c = {5'd22, 30'h3fffd6};    8'd137: c = {5'd23, 30'h7fffda};
            8'd138: c = {5'd23, 30'h7fffdb};    8'd139: c = {5'd23, 30'h7fffdc};
            8'd140: c = {5'd23, 30'h7fffdd};    8'd141: c = {5'd23, 30'h7fffde};
            8'd142: c = {5'd24, 30'hffffeb};    8'd143: c = {5'd23, 30'h7fffdf};
            8'd144: c = {5'd24, 30'hffffec};    8'd145: c = {5'd24, 30'hffffed};
            8'd146: c = {5'd22, 30'h3fffd7};    8'd147: c = {5'd23, 30'h7fffe0};
            8'd148: c = {5'd24, 30'hffffee};    8'd149: c = {5'd23, 30'h7fffe1};
            8'd150: c = {5'd23, 30'h7fffe2};    8'd151: c = {5'd23, 30'h7fffe3};
            8'd152: c = {5'd23, 30'h7fffe4};    8'd153: c = {5'd21, 30'h1fffdc};
            8'd154: c = {5'd22, 30'h3fffd8};    8'd155: c = {5'd23, 30'h7fffe5};
            8'd156: c = {5'd22, 30'h3fffd9};    8'd157: c = {5'd23, 30'h7fffe6};
            8'd158: c = {5'd23, 30'h7fffe7};    8'd159: c = {5'd24, 30'hffffef};
            8'd160: c = {5'd22, 30'h3fffda};    8'd161: c = {5'd21, 30'h1fffdd};
            8'd162: c = {5'd20, 30'hfffe9};     8'd163: c = {5'd22, 30'h3fffdb};
            8'd164: c = {5'd22, 30'h3fffdc};    8'd165: c = {5'd23, 30'h7fffe8};
            8'd166: c = {5'd23, 30'h7fffe9};    8'd167: c = {5'd21, 30'h1fffde};
            8'd168: c = {5'd23, 30'h7fffea};    8'd169: c = {5'd22, 30'h3fffdd};
            8'd170: c = {5'd22, 30'h3fffde};    8'd171: c = {5'd24, 30'hfffff0};
            8'd172: c = {5'd21, 30'h1fffdf};    8'd173: c = {5'd22, 30'h3fffdf};
            8'd174: c = {5'd23, 30'h7fffeb};    8'd175: c = {5'd23, 30'h7fffec};
            8'd176: c = {5'd21, 30'h1fffe0};    8'd177: c = {5'd21, 30'h1fffe1};
            8'd178: c = {5'd22, 30'h3fffe0};    8'd179: c = {5'd21, 30'h1fffe2};
            8'd180: c = {5'd23, 30'h7fffed};    8'd181: c = {5'd22, 30'h3fffe1};
            8'd182: c = {5'd23, 30'h7fffee};    8'd183: c = {5'd23, 30'h7fffef};
            8'd184: c = {5'd20, 30'hfffea};     8'd185: c = {5'd22, 30'h3fffe2};
            8'd186: c = {5'd22, 30'h3fffe3};    8'd187: c = {5'd22, 30'h3fffe4};
            8'd188: c = {5'd23, 30'h7ffff0};    8'd189: c = {5'd22, 30'h3fffe5};
            8'd190: c = {5'd22, 30'h3fffe6};    8'd191: c = {5'd23, 30'h7ffff1};
            8'd192: c = {5'd26, 30'h3ffffe0};   8'd193: c = {5'd26, 30'h3ffffe1};
            8'd194: c = {5'd20, 30'hfffeb};     8'd195: c = {5'd19, 30'h7fff1};
            8'd196: c = {5'd22, 30'h3fffe7};    8'd197: c = {5'd23, 30'h7ffff2};
            8'd198: c = {5'd22, 30'h3fffe8};    8'd199: c = {5'd25, 30'h1ffffec};
            8'd200: c = {5'd26, 30'h3ffffe2};   8'd201: c = {5'd26, 30'h3ffffe3};
            8'd202: c = {5'd26, 30'h3ffffe4};   8'd203: c = {5'd27, 30'h7ffffde};
            8'd204: c = {5'd27, 30'h7ffffdf};   8'd205: c = {5'd26, 30'h3ffffe5};
            8'd206: c = {5'd24, 30'hfffff1};    8'd207: c = {5'd25, 30'h1ffffed};
            8'd208: c = {5'd19, 30'h7fff2};     8'd209: c = {5'd21, 30'h1fffe3};
            8'd210: c = {5'd26, 30'h3ffffe6};   8'd211: c = {5'd27, 30'h7ffffe0};
            8'd212: c = {5'd27, 30'h7ffffe1};   8'd213: c = {5'd26, 30'h3ffffe7};
            8'd214: c = {5'd27, 30'h7ffffe2};   8'd215: c = {5'd24, 30'hfffff2};
            8'd216: c = {5'd21, 30'h1fffe4};    8'd217: c = {5'd21, 30'h1fffe5};
            8'd218: c = {5'd26, 30'h3ffffe8};   8'd219: c = {5'd26, 30'h3ffffe9};
            8'd220: c = {5'd28, 30'hffffffd};   8'd221: c = {5'd27, 30'h7ffffe3};
            8'd222: c = {5'd27, 30'h7ffffe4};   8'd223: c = {5'd27, 30'h7ffffe5};
            8'd224: c = {5'd20, 30'hfffec};     8'd225: c = {5'd24, 30'hfffff3};
            8'd226: c = {5'd20, 30'hfffed};     8'd227: c = {5'd21, 30'h1fffe6};
            8'd228: c = {5'd22, 30'h3fffe9};    8'd229: c = {5'd21, 30'h1fffe7};
            8'd230: c = {5'd21, 30'h1fffe8};    8'd231: c = {5'd23, 30'h7ffff3};
            8'd232: c = {5'd22, 30'h3fffea};    8'd233: c = {5'd22, 30'h3fffeb};
            8'd234: c = {5'd25, 30'h1ffffee};   8'd235: c = {5'd25, 30'h1ffffef};
            8'd236: c = {5'd24, 30'hfffff4};    8'd237: c = {5'd24, 30'hfffff5};
            8'd238: c = {5'd26, 30'h3ffffea};   8'd239: c = {5'd23, 30'h7ffff4};
            8'd240: c = {5'd26, 30'h3ffffeb};   8'd241: c = {5'd27, 30'h7ffffe6};
            8'd242: c = {5'd26, 30'h3ffffec};   8'd243: c = {5'd26, 30'h3ffffed};
            8'd244: c = {5'd27, 30'h7ffffe7};   8'd245: c = {5'd27, 30'h7ffffe8};
            8'd246: c = {5'd27, 30'h7ffffe9};   8'd247: c = {5'd27, 30'h7ffffea};
            8'd248: c = {5'd27, 30'h7ffffeb};   8'd249: c = {5'd28, 30'hffffffe};
            8'd250: c = {5'd27, 30'h7ffffec};   8'd251: c = {5'd27, 30'h7ffffed};
            8'd252: c = {5'd27, 30'h7ffffee};   8'd253: c = {5'd27, 30'h7ffffef};
            8'd254: c = {5'd27, 30'h7fffff0};   8'd255: c = {5'd26, 30'h3ffffee};
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/hpk_front.sv @@
// hpk_front: code lookup, bit packing with the pending bits and padding
// depends on hpk_pkg
`timescale 1ns / 1ps
`default_nettype none
module hpk_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_symbol,
    input  wire logic            i_end_of_string,
    output logic                 o_push,
    output hpk_pkg::t_entry      o_entry,
    input  wire logic            i_full
);
    import hpk_pkg::*;

    logic [PEND_W-1:0]  r_pend, n_pend;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    t_code              code;
    logic [ACC_W-1:0]   acc;
    logic [NBITS_W-1:0] nbits;
    logic [NBITS_W-1:0] lshift;
    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  padmask;
    logic [CNT_W-1:0]   nbytes;
    logic               accept;

    // join pending bits with the new code
    always_comb begin
        code    = code_lookup(i_symbol);
        acc     = ({{CODE_W{1'b0}}, r_pend} << code.len) | {{PEND_W{1'b0}}, code.bits};
        nbits   = NBITS_W'(r_cnt) + NBITS_W'(code.len);
        lshift  = NBITS_W'(WORD_W) - nbits;
        word    = {{(WORD_W-ACC_W){1'b0}}, acc} << lshift;
        padmask = ~({WORD_W{1'b1}} << lshift);
        nbytes  = CNT_W'(nbits >> 3) + CNT_W'(i_end_of_string && (nbits[2:0] != 3'd0));
    end

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (nbytes != '0);

    always_comb begin
        o_entry.word  = i_end_of_string ? (word | padmask) : word;
        o_entry.count = nbytes;
        o_entry.fin   = i_end_of_string;
    end

    // leftover bits carry to the next request
    always_comb begin
        n_pend = r_pend;
        n_cnt  = r_cnt;
        if (accept) begin
            if (i_end_of_string) begin
                n_pend = '0;
                n_cnt  = '0;
            end else begin
                n_cnt  = nbits[2:0];
                n_pend = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << nbits[2:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end
endmodule
`default_nettype wire

@@ rtl/hpk_queue.sv @@
// hpk_queue: two-entry queue of packed bit groups between front and back
// depends on hpk_pkg
`timescale 1ns / 1ps
`default_nettype none
module hpk_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  hpk_pkg::t_entry      i_entry,
    output logic                 o_full,
    output logic                 o_valid,
    output hpk_pkg::t_entry      o_entry,
    input  wire logic            i_pop
);
    import hpk_pkg::*;

    t_entry     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_num, n_num;

    assign o_full  = (r_num == 2'd2);
    assign o_valid = (r_num != 2'd0);
    assign o_entry = r_mem[r_rp];

    // occupancy
    always_comb begin
        n_num = r_num;
        case ({i_push, i_pop})
            2'b10:   n_num = r_num + 2'd1;
            2'b01:   n_num = r_num - 2'd1;
            default: n_num = r_num;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_num <= '0;
        end else begin
            r_num <= n_num;
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end
endmodule
`default_nettype wire

@@ rtl/hpk_back.sv @@
// hpk_back: slices queued bit groups into bytes, one per cycle unless the
// output stalls, into an output register; depends on hpk_pkg
`timescale 1ns / 1ps
`default_nettype none
module hpk_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  hpk_pkg::t_entry      i_entry,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_last_byte
);
    import hpk_pkg::*;

    logic [CNT_W-1:0]  r_idx;
    logic              r_valid;
    logic [7:0]        r_byte;
    logic              r_last;
    logic              load;
    logic              at_end;
    logic [WORD_W-1:0] shifted;

    // pick the current byte from the head group
    always_comb begin
        shifted = i_entry.word << {r_idx, 3'b000};
        at_end  = (r_idx == i_entry.count - CNT_W'(1));
        load    = i_valid && (!r_valid || i_ready);
    end

    assign o_pop       = load && at_end;
    assign o_valid     = r_valid;
    assign o_out_byte  = r_byte;
    assign o_last_byte = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? '0 : r_idx + CNT_W'(1);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= shifted[WORD_W-1 -: 8];
            r_last <= i_entry.fin && at_end;
        end
    end
endmodule
`default_nettype wire

@@ rtl/hpack_huffman_encoder_top.sv @@
// hpack_huffman_encoder_top: static huffman string encoder top level
// depends on hpk_pkg, hpk_front, hpk_queue, hpk_back
`timescale 1ns / 1ps
`default_nettype none
// Encodes header string octets with the static huffman code. One octet is
// taken per request; the front packs its 5 to 30 bit code behind the pending
// bits in the same cycle and queues the group of completed bytes (up to five,
// the last padded with ones and flagged at end of string). The back emits
// one byte per cycle unless the output stalls; the two-entry queue lets the
// front run ahead of stalls.
module hpack_huffman_encoder_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_symbol,
    input  wire logic       i_end_of_string,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last_byte
);
    import hpk_pkg::*;

    logic   push, full, q_valid, pop;
    t_entry f_entry, q_entry;

    hpk_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_in_valid), .o_ready(o_in_ready),
        .i_symbol, .i_end_of_string,
        .o_push(push), .o_entry(f_entry), .i_full(full)
    );

    hpk_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(push), .i_entry(f_entry), .o_full(full),
        .o_valid(q_valid), .o_entry(q_entry), .i_pop(pop)
    );

    hpk_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .i_entry(q_entry), .o_pop(pop),
        .o_valid(o_out_valid), .i_ready(i_out_ready),
        .o_out_byte, .o_last_byte
    );
endmodule
`default_nettype wire
